### hw/rtl/tpsc_pkg.sv
// shared types and constants of the triangle plane set classifier
`default_nettype none

package tpsc_pkg;

    // number of plane registers in the configuration map
    localparam int PLANE_REGS = 6;
    localparam int PIDX_W     = $clog2(PLANE_REGS);

    // configuration register indexes
    localparam logic [2:0] CFG_MODE        = 3'd0;
    localparam logic [2:0] CFG_PLANE_COUNT = 3'd1;
    localparam logic [2:0] CFG_PLANE_A     = 3'd2;
    localparam logic [2:0] CFG_PLANE_G     = 3'd7;

    // mode codes
    localparam logic MODE_SINGLE = 1'b0;
    localparam logic MODE_SET    = 1'b1;

    // reset value of the plane count register
    localparam logic [2:0] PLANE_COUNT_RESET = 3'd6;

    // single plane verdict codes
    localparam logic [1:0] V_BEHIND     = 2'd0;
    localparam logic [1:0] V_IN_FRONT   = 2'd1;
    localparam logic [1:0] V_INTERSECTS = 2'd2;

    // input item: one triangle
    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] bx;
        logic signed [15:0] by_coord;
        logic signed [15:0] bz;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] cz;
        logic               first_tri;
        logic               last_tri;
    } t_in_item;

    // result item: one mesh verdict
    typedef struct packed {
        logic [1:0]  single_verdict;
        logic        set_verdict;
        logic [15:0] culled_count;
        logic [15:0] seen_count;
    } t_out_item;

    // classified triangle passed from front to back
    typedef struct packed {
        logic       first_tri;
        logic       last_tri;
        logic       mode;
        logic       culled;
        logic [1:0] verdict;
    } t_cls;

endpackage

`default_nettype wire

### hw/rtl/tpsc_front.sv
// front end: accepts triangles and classifies them against the planes, one plane a cycle
`default_nettype none

module tpsc_front
    import tpsc_pkg::*;
#(
    parameter int MAX_PLANES = 6
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_item,
    input  wire logic        i_mode,
    input  wire logic [2:0]  i_plane_count,
    input  wire logic [63:0] i_plane [PLANE_REGS],
    output logic             o_push,
    output t_cls             o_cls,
    input  wire logic        i_full
);

    localparam int LIM_MAX = (MAX_PLANES < PLANE_REGS) ? MAX_PLANES : PLANE_REGS;
    localparam int LIM_W   = $clog2(LIM_MAX + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EVAL = 3'b010,
        S_PUSH = 3'b100
    } t_state;

    t_state                   r_state, n_state;
    t_in_item                 r_item, n_item;
    logic                     r_mode, n_mode;
    logic [LIM_W-1:0]         r_lim, n_lim;
    logic [LIM_W-1:0]         r_issue, n_issue;
    logic                     r_prod_vld, n_prod_vld;
    logic signed [31:0]       r_prod [3][3];
    logic signed [31:0]       n_prod [3][3];
    logic signed [15:0]       r_d, n_d;
    logic                     r_culled, n_culled;
    logic [1:0]               r_sv, n_sv;

    logic signed [15:0]       w_vtx [3][3];
    logic signed [15:0]       w_n [3];
    logic signed [31:0]       w_prod [3][3];
    logic [63:0]              w_plane;
    logic signed [34:0]       w_sum [3];
    logic [2:0]               w_neg;
    logic [1:0]               w_sv;
    logic [LIM_W-1:0]         w_lim_set;

    // vertex unpack
    always_comb begin
        w_vtx[0][0] = r_item.ax;
        w_vtx[0][1] = r_item.ay;
        w_vtx[0][2] = r_item.az;
        w_vtx[1][0] = r_item.bx;
        w_vtx[1][1] = r_item.by_coord;
        w_vtx[1][2] = r_item.bz;
        w_vtx[2][0] = r_item.cx;
        w_vtx[2][1] = r_item.cy;
        w_vtx[2][2] = r_item.cz;
    end

    // plane select and multiplier bank, one plane times three vertices
    assign w_plane = i_plane[PIDX_W'(r_issue)];
    assign w_n[0]  = w_plane[15:0];
    assign w_n[1]  = w_plane[31:16];
    assign w_n[2]  = w_plane[47:32];

    always_comb begin
        for (int v = 0; v < 3; v++) begin
            for (int k = 0; k < 3; k++) begin
                w_prod[v][k] = w_n[k] * w_vtx[v][k];
            end
        end
    end

    // sum stage: sign of n.p + d per vertex
    always_comb begin
        for (int v = 0; v < 3; v++) begin
            w_sum[v] = 35'(r_prod[v][0]) + 35'(r_prod[v][1]) + 35'(r_prod[v][2])
                     + (35'(r_d) <<< 14);
            w_neg[v] = w_sum[v][34];
        end
        if (w_neg == 3'b000) begin
            w_sv = V_IN_FRONT;
        end else if (w_neg == 3'b111) begin
            w_sv = V_BEHIND;
        end else begin
            w_sv = V_INTERSECTS;
        end
    end

    // enabled planes in set mode, clamped
    assign w_lim_set = (i_plane_count > LIM_MAX) ? LIM_W'(LIM_MAX) : LIM_W'(i_plane_count);

    assign o_in_stall = (r_state != S_IDLE);
    assign o_push     = (r_state == S_PUSH) && !i_full;
    assign o_cls      = '{first_tri: r_item.first_tri, last_tri: r_item.last_tri,
                          mode: r_mode, culled: r_culled, verdict: r_sv};

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_item     = r_item;
        n_mode     = r_mode;
        n_lim      = r_lim;
        n_issue    = r_issue;
        n_prod_vld = 1'b0;
        n_prod     = r_prod;
        n_d        = r_d;
        n_culled   = r_culled;
        n_sv       = r_sv;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item   = i_in_item;
                    n_mode   = i_mode;
                    n_lim    = (i_mode == MODE_SINGLE) ? LIM_W'(1) : w_lim_set;
                    n_issue  = '0;
                    n_culled = 1'b0;
                    n_sv     = V_BEHIND;
                    n_state  = S_EVAL;
                end
            end
            S_EVAL: begin
                // issue the next plane into the multipliers
                if (r_issue != r_lim) begin
                    n_prod     = w_prod;
                    n_d        = w_plane[63:48];
                    n_prod_vld = 1'b1;
                    n_issue    = r_issue + 1'b1;
                end
                // fold the previous plane into the verdict
                if (r_prod_vld) begin
                    n_culled = r_culled | (w_neg == 3'b111);
                    n_sv     = w_sv;
                end
                if ((r_issue == r_lim) && !r_prod_vld) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!i_full) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_prod_vld <= 1'b0;
            r_issue    <= '0;
            r_lim      <= '0;
        end else begin
            r_state    <= n_state;
            r_prod_vld <= n_prod_vld;
            r_issue    <= n_issue;
            r_lim      <= n_lim;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_mode   <= n_mode;
        r_prod   <= n_prod;
        r_d      <= n_d;
        r_culled <= n_culled;
        r_sv     <= n_sv;
    end

    // the plane counter never runs past the enabled planes
    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> (r_issue <= r_lim))
        else $error("plane counter past limit");

endmodule

`default_nettype wire

### hw/rtl/tpsc_queue.sv
// two entry queue of classified triangles between front and back
`default_nettype none

module tpsc_queue
    import tpsc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cls i_cls,
    output logic      o_full,
    input  wire logic i_pop,
    output t_cls      o_cls,
    output logic      o_empty
);

    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);

    t_cls          r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW + 1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cls   = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cls;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty queue");

endmodule

`default_nettype wire

### hw/rtl/tpsc_back.sv
// back end: mesh tallies, sticky verdict and the result register
`default_nettype none

module tpsc_back
    import tpsc_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cls i_cls,
    input  wire logic i_empty,
    output logic      o_pop,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out_item o_out_item
);

    logic [COUNT_WIDTH-1:0] r_seen, n_seen;
    logic [COUNT_WIDTH-1:0] r_culled, n_culled;
    logic [1:0]             r_sticky, n_sticky;
    logic                   r_out_vld;
    t_out_item              r_out, n_out;

    logic [COUNT_WIDTH-1:0] w_base_seen, w_base_culled;
    logic [1:0]             w_base_sticky;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] t);
        return (t != '1) ? t + 1'b1 : t;
    endfunction

    function automatic logic [15:0] clamp16(input logic [COUNT_WIDTH-1:0] t);
        return (t > COUNT_WIDTH'(16'hFFFF)) ? 16'hFFFF : 16'(t);
    endfunction

    // take a record once the result register can hold a new item
    assign o_pop = !i_empty && (!r_out_vld || !i_out_stall);

    // tally and verdict update
    always_comb begin
        w_base_seen   = i_cls.first_tri ? '0 : r_seen;
        w_base_culled = i_cls.first_tri ? '0 : r_culled;
        w_base_sticky = i_cls.first_tri ? V_BEHIND : r_sticky;

        n_seen   = sat_inc(w_base_seen);
        n_culled = w_base_culled;
        n_sticky = w_base_sticky;
        if (i_cls.mode == MODE_SINGLE) begin
            if (w_base_sticky == V_BEHIND) begin
                n_sticky = i_cls.verdict;
            end
        end else if (i_cls.culled) begin
            n_culled = sat_inc(w_base_culled);
        end

        // result fields
        n_out.seen_count = clamp16(n_seen);
        if (i_cls.mode == MODE_SINGLE) begin
            n_out.single_verdict = n_sticky;
            n_out.set_verdict    = 1'b0;
            n_out.culled_count   = '0;
        end else begin
            n_out.single_verdict = V_BEHIND;
            n_out.set_verdict    = (n_culled != n_seen);
            n_out.culled_count   = clamp16(n_culled);
        end
    end

    // mesh state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= '0;
            r_culled  <= '0;
            r_sticky  <= V_BEHIND;
            r_out_vld <= 1'b0;
        end else begin
            if (o_pop) begin
                r_seen   <= n_seen;
                r_culled <= n_culled;
                r_sticky <= n_sticky;
            end
            if (o_pop && i_cls.last_tri) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_pop && i_cls.last_tri) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    // every result covers at least the triangle that closed the mesh
    a_seen_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.seen_count != 16'd0))
        else $error("result with zero seen count");

endmodule

`default_nettype wire

### hw/rtl/triangle_plane_set_classifier.sv
// top level: configuration registers, front end, queue and back end
// Classifies a mesh, streamed one triangle per item, against configured planes.
// Input channel: i_in_valid / o_in_stall with i_in_item (three vertices, Q8.8,
// plus first_tri and last_tri). An item is taken when valid is high and stall low.
// Output channel: o_out_valid / i_out_stall with o_out_item; one result item is
// produced for each triangle with last_tri set.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// index 0 mode, 1 plane count, 2 to 7 the six planes. Write only while idle.
// The front end evaluates N planes, N = 1 in single mode and the clamped plane
// count in set mode, one plane per cycle through one bank of nine 16x16
// multipliers; it stalls the input until the triangle is pushed into the queue.
// A two entry queue lets the front end keep classifying while a result waits.
// When the receiver stalls, the result holds and the queue fills, then the
// input stalls. Reset sets mode to plane set, plane count to six, clears the
// planes, tallies and sticky verdict, and empties the queue.
`default_nettype none

module triangle_plane_set_classifier
    import tpsc_pkg::*;
#(
    parameter int MAX_PLANES  = 6,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_item,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out_item,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);

    logic        r_mode;
    logic [2:0]  r_plane_count;
    logic [63:0] r_plane [PLANE_REGS];

    logic        w_push, w_full, w_pop, w_empty;
    t_cls        w_cls_in, w_cls_out;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_SET;
            r_plane_count <= PLANE_COUNT_RESET;
            for (int i = 0; i < PLANE_REGS; i++) begin
                r_plane[i] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index) inside
                CFG_MODE:        r_mode        <= i_cfg_data[0];
                CFG_PLANE_COUNT: r_plane_count <= i_cfg_data[2:0];
                [CFG_PLANE_A:CFG_PLANE_G]: begin
                    r_plane[PIDX_W'(i_cfg_index - CFG_PLANE_A)] <= i_cfg_data;
                end
                default: ;
            endcase
        end
    end

    tpsc_front #(
        .MAX_PLANES (MAX_PLANES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_item     (i_in_item),
        .i_mode        (r_mode),
        .i_plane_count (r_plane_count),
        .i_plane       (r_plane),
        .o_push        (w_push),
        .o_cls         (w_cls_in),
        .i_full        (w_full)
    );

    tpsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cls   (w_cls_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_cls   (w_cls_out),
        .o_empty (w_empty)
    );

    tpsc_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cls       (w_cls_out),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire
